@@ hdl/lvm_pkg.sv @@
// ----------------------------------------------------------------------------
// lvm_pkg
// Shared types, pipeline depths and rounding helpers for the look-at
// view matrix pipeline.
// ----------------------------------------------------------------------------
package lvm_pkg;

  typedef logic signed [31:0] fix_t;
  typedef logic signed [63:0] wide_t;

  // normalize unit: front end, root steps, numerator setup, quotient steps, output
  localparam int RootSteps = 32;
  localparam int QuoBits   = 31;
  localparam int UNIT_LAT  = 4 + RootSteps + 1 + QuoBits + 1;

  // input register, two normalize units, cross stages, back end
  localparam int PIPE_LAT  = 1 + UNIT_LAT + 2 + UNIT_LAT + 6;

  // Round a Q4.60 value to Q2.30, half away from zero, clamp to +-1.0
  function automatic fix_t rnd_unit(wide_t v);
    logic [63:0] mag;
    logic [33:0] r;
    fix_t        res;
    mag = v[63] ? 64'(-v) : 64'(v);
    r   = 34'((mag + 64'(64'd1 << 29)) >> 30);
    if (v[63]) begin
      res = (r > 34'h040000000) ? -32'sh40000000 : 32'(35'sd0 - $signed({1'b0, r}));
    end else begin
      res = (r > 34'h040000000) ? 32'sh40000000 : 32'(r);
    end
    return res;
  endfunction

  // Round a Q18.46 value to Q16.16, half away from zero, saturate to 32 bits
  function automatic fix_t rnd_q16(wide_t v);
    logic [63:0] mag;
    logic [33:0] r;
    fix_t        res;
    mag = v[63] ? 64'(-v) : 64'(v);
    r   = 34'((mag + 64'(64'd1 << 29)) >> 30);
    if (v[63]) begin
      res = (r > 34'h080000000) ? 32'sh80000000 : 32'(35'sd0 - $signed({1'b0, r}));
    end else begin
      res = (r > 34'h07FFFFFFF) ? 32'sh7FFFFFFF : 32'(r);
    end
    return res;
  endfunction

endpackage

@@ hdl/lvm_unit.sv @@
// ----------------------------------------------------------------------------
// lvm_unit
// Pipelined vector normalizer: scales a 3-vector so its largest magnitude
// sits in [2^29, 2^30), takes the integer square root one step per stage and
// divides each component by the length one quotient bit per stage. Output
// is Q2.30; an all-zero vector gives zeros.
// ----------------------------------------------------------------------------
module lvm_unit import lvm_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  wide_t vec_i  [3],
  output fix_t  unit_o [3]
);

  // front end registers
  logic [62:0] mag_s0_q [3];
  logic [2:0]  neg_s0_q;
  logic [29:0] sm_s1_q  [3];
  logic [2:0]  neg_s1_q;
  logic        zero_s1_q;
  logic [59:0] sq_s2_q  [3];
  logic [29:0] sm_s2_q  [3];
  logic [2:0]  neg_s2_q;
  logic        zero_s2_q;
  logic [61:0] sum_s3_q;
  logic [29:0] sm_s3_q  [3];
  logic [2:0]  neg_s3_q;
  logic        zero_s3_q;

  // split magnitude and sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        neg_s0_q[i] <= vec_i[i][63];
        mag_s0_q[i] <= 63'(vec_i[i][63] ? -vec_i[i] : vec_i[i]);
      end
    end
  end

  // find the bit length of the largest magnitude and scale all three
  logic [62:0] or_s1;
  logic [5:0]  blen_s1;
  logic [29:0] sm_s1_d [3];

  always_comb begin
    or_s1   = mag_s0_q[0] | mag_s0_q[1] | mag_s0_q[2];
    blen_s1 = '0;
    for (int k = 0; k < 63; k++) begin
      if (or_s1[k]) blen_s1 = 6'(k + 1);
    end
    for (int i = 0; i < 3; i++) begin
      if (blen_s1 > 6'd30) sm_s1_d[i] = 30'(mag_s0_q[i] >> (blen_s1 - 6'd30));
      else                 sm_s1_d[i] = 30'(mag_s0_q[i] << (6'd30 - blen_s1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sm_s1_q   <= sm_s1_d;
      neg_s1_q  <= neg_s0_q;
      zero_s1_q <= (or_s1 == '0);
    end
  end

  // square the scaled magnitudes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq_s2_q[i] <= sm_s1_q[i] * sm_s1_q[i];
      end
      sm_s2_q   <= sm_s1_q;
      neg_s2_q  <= neg_s1_q;
      zero_s2_q <= zero_s1_q;
    end
  end

  // sum of squares
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_s3_q  <= 62'(sq_s2_q[0]) + 62'(sq_s2_q[1]) + 62'(sq_s2_q[2]);
      sm_s3_q   <= sm_s2_q;
      neg_s3_q  <= neg_s2_q;
      zero_s3_q <= zero_s2_q;
    end
  end

  // integer square root, two radicand bits per stage
  logic [61:0] rt_rem_q  [RootSteps];
  logic [62:0] rt_res_q  [RootSteps];
  logic [29:0] rt_mag_q  [RootSteps][3];
  logic [2:0]  rt_neg_q  [RootSteps];
  logic        rt_zero_q [RootSteps];

  for (genvar j = 0; j < RootSteps; j++) begin : g_root
    localparam logic [62:0] Bit = 63'(1) << (62 - 2 * j);
    logic [61:0] rem_in;
    logic [62:0] res_in;
    logic [29:0] mag_in [3];
    logic [2:0]  neg_in;
    logic        zero_in;
    logic [61:0] rem_d;
    logic [62:0] res_d;

    if (j == 0) begin : g_first
      assign rem_in  = sum_s3_q;
      assign res_in  = '0;
      assign mag_in  = sm_s3_q;
      assign neg_in  = neg_s3_q;
      assign zero_in = zero_s3_q;
    end else begin : g_next
      assign rem_in  = rt_rem_q[j-1];
      assign res_in  = rt_res_q[j-1];
      assign mag_in  = rt_mag_q[j-1];
      assign neg_in  = rt_neg_q[j-1];
      assign zero_in = rt_zero_q[j-1];
    end

    always_comb begin
      if ({1'b0, rem_in} >= res_in + Bit) begin
        rem_d = 62'({1'b0, rem_in} - res_in - Bit);
        res_d = (res_in >> 1) + Bit;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_rem_q[j]  <= rem_d;
        rt_res_q[j]  <= res_d;
        rt_mag_q[j]  <= mag_in;
        rt_neg_q[j]  <= neg_in;
        rt_zero_q[j] <= zero_in;
      end
    end
  end

  // set up rounded numerators against the length
  logic [30:0] len_p_q;
  logic [60:0] num_p_q [3];
  logic [2:0]  neg_p_q;
  logic        zero_p_q;
  logic [30:0] len_p_d;

  assign len_p_d = 31'(rt_res_q[RootSteps-1]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_p_q <= len_p_d;
      for (int i = 0; i < 3; i++) begin
        num_p_q[i] <= {1'b0, rt_mag_q[RootSteps-1][i], 30'b0} + 61'(len_p_d >> 1);
      end
      neg_p_q  <= rt_neg_q[RootSteps-1];
      zero_p_q <= rt_zero_q[RootSteps-1];
    end
  end

  // restoring division, one quotient bit per stage, three lanes
  logic [60:0] dv_rem_q  [QuoBits][3];
  logic [30:0] dv_quo_q  [QuoBits][3];
  logic [30:0] dv_len_q  [QuoBits];
  logic [2:0]  dv_neg_q  [QuoBits];
  logic        dv_zero_q [QuoBits];

  for (genvar k = 0; k < QuoBits; k++) begin : g_quo
    localparam int Pos = QuoBits - 1 - k;
    logic [60:0] rem_in [3];
    logic [30:0] quo_in [3];
    logic [30:0] len_in;
    logic [2:0]  neg_in;
    logic        zero_in;
    logic [61:0] trial;
    logic [60:0] rem_d  [3];
    logic [30:0] quo_d  [3];

    if (k == 0) begin : g_first
      assign rem_in  = num_p_q;
      assign quo_in  = '{default: '0};
      assign len_in  = len_p_q;
      assign neg_in  = neg_p_q;
      assign zero_in = zero_p_q;
    end else begin : g_next
      assign rem_in  = dv_rem_q[k-1];
      assign quo_in  = dv_quo_q[k-1];
      assign len_in  = dv_len_q[k-1];
      assign neg_in  = dv_neg_q[k-1];
      assign zero_in = dv_zero_q[k-1];
    end

    assign trial = 62'(len_in) << Pos;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, rem_in[i]} >= trial) begin
          rem_d[i] = 61'({1'b0, rem_in[i]} - trial);
          quo_d[i] = quo_in[i] | (31'(1) << Pos);
        end else begin
          rem_d[i] = rem_in[i];
          quo_d[i] = quo_in[i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_rem_q[k]  <= rem_d;
        dv_quo_q[k]  <= quo_d;
        dv_len_q[k]  <= len_in;
        dv_neg_q[k]  <= neg_in;
        dv_zero_q[k] <= zero_in;
      end
    end
  end

  // apply sign, force zero vector to zero
  fix_t unit_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero_q[QuoBits-1]) begin
          unit_q[i] <= '0;
        end else if (dv_neg_q[QuoBits-1][i]) begin
          unit_q[i] <= 32'(32'sd0 - $signed({1'b0, dv_quo_q[QuoBits-1][i]}));
        end else begin
          unit_q[i] <= $signed({1'b0, dv_quo_q[QuoBits-1][i]});
        end
      end
    end
  end

  assign unit_o = unit_q;

endmodule

@@ hdl/look_at_view_matrix_unit.sv @@
// Throughput: one pose per cycle; the whole pipeline advances together and
// holds while a result waits on the output and the output is not ready.
// Depth is set by the two normalizers: 32 square-root and 31 quotient stages.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit
// Right-handed look-at view basis: forward, left and up axes in Q2.30 and
// the three eye translations in Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit import lvm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, upward_x, upward_y, upward_z
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // left_x, left_y, left_z, newup_x, newup_y, newup_z, fwd_x, fwd_y, fwd_z,
  // trans_left, trans_up, trans_fwd
  output logic [383:0] m_axis_tdata
);

  logic                en;
  logic [PIPE_LAT-1:0] vld_q;

  // advance the pipeline unless the output holds an untaken result
  assign en            = !vld_q[PIPE_LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid};
    end
  end

  // input register: eye minus aim, and the eye and up vectors
  wide_t d_p0_q   [3];
  fix_t  eye_p0_q [3];
  fix_t  upv_p0_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        eye_p0_q[i] <= s_axis_tdata[32*i +: 32];
        upv_p0_q[i] <= s_axis_tdata[192 + 32*i +: 32];
        d_p0_q[i]   <= 64'($signed(s_axis_tdata[32*i +: 32]))
                     - 64'($signed(s_axis_tdata[96 + 32*i +: 32]));
      end
    end
  end

  // forward axis
  fix_t fwd_a [3];

  lvm_unit u_fwd (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (d_p0_q),
    .unit_o (fwd_a)
  );

  // delay eye and up alongside the forward normalizer
  fix_t eye_da_q [UNIT_LAT][3];
  fix_t upv_da_q [UNIT_LAT][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      eye_da_q[0] <= eye_p0_q;
      upv_da_q[0] <= upv_p0_q;
      for (int k = 1; k < UNIT_LAT; k++) begin
        eye_da_q[k] <= eye_da_q[k-1];
        upv_da_q[k] <= upv_da_q[k-1];
      end
    end
  end

  // up cross forward: partial products
  wide_t pc_t1_q  [6];
  fix_t  f_t1_q   [3];
  fix_t  eye_t1_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pc_t1_q[0] <= upv_da_q[UNIT_LAT-1][1] * fwd_a[2];
      pc_t1_q[1] <= upv_da_q[UNIT_LAT-1][2] * fwd_a[1];
      pc_t1_q[2] <= upv_da_q[UNIT_LAT-1][2] * fwd_a[0];
      pc_t1_q[3] <= upv_da_q[UNIT_LAT-1][0] * fwd_a[2];
      pc_t1_q[4] <= upv_da_q[UNIT_LAT-1][0] * fwd_a[1];
      pc_t1_q[5] <= upv_da_q[UNIT_LAT-1][1] * fwd_a[0];
      f_t1_q     <= fwd_a;
      eye_t1_q   <= eye_da_q[UNIT_LAT-1];
    end
  end

  // up cross forward: differences
  wide_t c_t2_q   [3];
  fix_t  f_t2_q   [3];
  fix_t  eye_t2_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c_t2_q[i] <= pc_t1_q[2*i] - pc_t1_q[2*i+1];
      end
      f_t2_q   <= f_t1_q;
      eye_t2_q <= eye_t1_q;
    end
  end

  // left axis
  fix_t left_b [3];

  lvm_unit u_left (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (c_t2_q),
    .unit_o (left_b)
  );

  // delay forward and eye alongside the left normalizer
  fix_t f_db_q   [UNIT_LAT][3];
  fix_t eye_db_q [UNIT_LAT][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_db_q[0]   <= f_t2_q;
      eye_db_q[0] <= eye_t2_q;
      for (int k = 1; k < UNIT_LAT; k++) begin
        f_db_q[k]   <= f_db_q[k-1];
        eye_db_q[k] <= eye_db_q[k-1];
      end
    end
  end

  // forward cross left: partial products
  wide_t pu_t3_q  [6];
  fix_t  l_t3_q   [3];
  fix_t  f_t3_q   [3];
  fix_t  eye_t3_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pu_t3_q[0] <= f_db_q[UNIT_LAT-1][1] * left_b[2];
      pu_t3_q[1] <= f_db_q[UNIT_LAT-1][2] * left_b[1];
      pu_t3_q[2] <= f_db_q[UNIT_LAT-1][2] * left_b[0];
      pu_t3_q[3] <= f_db_q[UNIT_LAT-1][0] * left_b[2];
      pu_t3_q[4] <= f_db_q[UNIT_LAT-1][0] * left_b[1];
      pu_t3_q[5] <= f_db_q[UNIT_LAT-1][1] * left_b[0];
      l_t3_q     <= left_b;
      f_t3_q     <= f_db_q[UNIT_LAT-1];
      eye_t3_q   <= eye_db_q[UNIT_LAT-1];
    end
  end

  // forward cross left: differences
  wide_t ud_t4_q  [3];
  fix_t  l_t4_q   [3];
  fix_t  f_t4_q   [3];
  fix_t  eye_t4_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ud_t4_q[i] <= pu_t3_q[2*i] - pu_t3_q[2*i+1];
      end
      l_t4_q   <= l_t3_q;
      f_t4_q   <= f_t3_q;
      eye_t4_q <= eye_t3_q;
    end
  end

  // round and clamp the up axis
  fix_t u_t5_q   [3];
  fix_t l_t5_q   [3];
  fix_t f_t5_q   [3];
  fix_t eye_t5_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_t5_q[i] <= rnd_unit(ud_t4_q[i]);
      end
      l_t5_q   <= l_t4_q;
      f_t5_q   <= f_t4_q;
      eye_t5_q <= eye_t4_q;
    end
  end

  // axis times eye products: rows left, up, forward
  wide_t pe_t6_q [3][3];
  fix_t  u_t6_q  [3];
  fix_t  l_t6_q  [3];
  fix_t  f_t6_q  [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pe_t6_q[0][i] <= l_t5_q[i] * eye_t5_q[i];
        pe_t6_q[1][i] <= u_t5_q[i] * eye_t5_q[i];
        pe_t6_q[2][i] <= f_t5_q[i] * eye_t5_q[i];
      end
      u_t6_q <= u_t5_q;
      l_t6_q <= l_t5_q;
      f_t6_q <= f_t5_q;
    end
  end

  // negated dot products
  wide_t dot_t7_q [3];
  fix_t  u_t7_q   [3];
  fix_t  l_t7_q   [3];
  fix_t  f_t7_q   [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        dot_t7_q[r] <= 64'sd0 - pe_t6_q[r][0] - pe_t6_q[r][1] - pe_t6_q[r][2];
      end
      u_t7_q <= u_t6_q;
      l_t7_q <= l_t6_q;
      f_t7_q <= f_t6_q;
    end
  end

  // output register
  fix_t left_q  [3];
  fix_t newup_q [3];
  fix_t fwd_q   [3];
  fix_t trans_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        trans_q[r] <= rnd_q16(dot_t7_q[r]);
      end
      left_q  <= l_t7_q;
      newup_q <= u_t7_q;
      fwd_q   <= f_t7_q;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_pack
    assign m_axis_tdata[32*i +: 32]       = left_q[i];
    assign m_axis_tdata[96 + 32*i +: 32]  = newup_q[i];
    assign m_axis_tdata[192 + 32*i +: 32] = fwd_q[i];
    assign m_axis_tdata[288 + 32*i +: 32] = trans_q[i];
  end

  // the first components of the forward and left axes never exceed one in magnitude
  a_fwd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (fwd_q[0] <= 32'sh40000000 && fwd_q[0] >= -32'sh40000000 &&
                       left_q[0] <= 32'sh40000000 && left_q[0] >= -32'sh40000000))
    else $error("axis component out of unit range");

  // a zero forward axis forces zero left and up axes
  a_zero_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && fwd_q[0] == '0 && fwd_q[1] == '0 && fwd_q[2] == '0) |->
    (left_q[0] == '0 && left_q[1] == '0 && left_q[2] == '0 && newup_q[0] == '0 &&
     newup_q[1] == '0 && newup_q[2] == '0))
    else $error("zero forward axis with nonzero left or up");

  // a zero left axis gives a zero left translation
  a_zero_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && left_q[0] == '0 && left_q[1] == '0 && left_q[2] == '0) |->
    (trans_q[0] == '0))
    else $error("zero left axis with nonzero translation");

endmodule
